// ----- src/rcrs_pkg.sv -----
// Package for the RC-discharge reflectance sensor array.
// Shared constants and types; no dependencies.
package rcrs_pkg;
    localparam int unsigned DefChannels = 8;
    localparam int unsigned PinBits     = 8;
    localparam int unsigned TimeW       = 11;
    localparam int unsigned RegW        = 11;
    localparam int unsigned IdxW        = 2;
    localparam int unsigned LevelW      = 8;
    localparam logic [TimeW-1:0] TimeMax = 11'd2047;
    localparam logic [LevelW-1:0] LevelFull = 8'd255;

    localparam logic [1:0] ModeTick  = 2'd0;
    localparam logic [1:0] ModeStart = 2'd1;
    localparam logic [1:0] ModeLatch = 2'd2;

    localparam logic [IdxW-1:0] RegCharge  = 2'd0;
    localparam logic [IdxW-1:0] RegTimeout = 2'd1;
    localparam logic [IdxW-1:0] RegCut     = 2'd2;

    typedef struct packed {
        logic             sense;   // sensing tick
        logic [TimeW-1:0] count;   // tick count after increment
        logic [9:0]       timeout;
    } t_lane_ctl;
endpackage

// ----- src/rcrs_lane.sv -----
// One sensor channel: discharge detection and calibration stores.
// Depends on rcrs_pkg.
module rcrs_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_latch,
    input  logic                      i_update,
    input  logic                      i_pin,
    input  rcrs_pkg::t_lane_ctl       i_ctl,
    output logic                      o_done,
    output logic [rcrs_pkg::TimeW-1:0] o_resp,
    output logic [rcrs_pkg::TimeW-1:0] o_min,
    output logic [rcrs_pkg::TimeW-1:0] o_max,
    output logic [rcrs_pkg::TimeW-1:0] o_thr
);
    logic                       r_done;
    logic [rcrs_pkg::TimeW-1:0] r_resp, r_min, r_max, r_thr;
    logic                       stop;
    logic [rcrs_pkg::TimeW:0]   sum;

    assign stop = i_ctl.sense && !r_done &&
                  (!i_pin || i_ctl.count > {1'b0, i_ctl.timeout});
    assign sum  = {1'b0, r_min} + {1'b0, r_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_resp <= '0;
            r_min  <= rcrs_pkg::TimeMax;
            r_max  <= '0;
            r_thr  <= '0;
        end else begin
            if (i_start) begin
                r_done <= 1'b0;
                r_resp <= '0;
            end else if (stop) begin
                r_done <= 1'b1;
                r_resp <= i_ctl.count;
            end
            if (i_latch) r_thr <= sum[rcrs_pkg::TimeW:1];
            if (i_update) begin
                if (r_resp > r_max) r_max <= r_resp;
                if (r_resp < r_min) r_min <= r_resp;
            end
        end
    end

    assign o_done = r_done | stop;
    assign o_resp = r_resp;
    assign o_min  = r_min;
    assign o_max  = r_max;
    assign o_thr  = r_thr;
endmodule

// ----- src/rcrs_div.sv -----
// Restoring divider for the level: 255 - floor(off*255/span), one bit a cycle.
// Depends on rcrs_pkg.
module rcrs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [rcrs_pkg::TimeW-1:0] i_resp,
    input  logic [rcrs_pkg::TimeW-1:0] i_lo,
    input  logic [rcrs_pkg::TimeW-1:0] i_hi,
    output logic                       o_done,
    output logic [rcrs_pkg::LevelW-1:0] o_level
);
    localparam int unsigned NumW = rcrs_pkg::TimeW + 8;
    logic [NumW-1:0]            r_num;
    logic [rcrs_pkg::TimeW:0]   r_rem;
    logic [rcrs_pkg::TimeW-1:0] r_span;
    logic [4:0]                 r_cnt;
    logic                       r_run, r_zero;
    logic [rcrs_pkg::TimeW-1:0] span, off, offc;
    logic [rcrs_pkg::TimeW:0]   trial;

    assign span  = i_hi - i_lo;
    assign off   = (i_resp > i_lo) ? i_resp - i_lo : '0;
    assign offc  = (off > span) ? span : off;
    assign trial = {r_rem[rcrs_pkg::TimeW-1:0], r_num[NumW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_go) begin
            r_run  <= 1'b1;
            r_zero <= (i_hi <= i_lo);
            r_span <= span;
            r_num  <= ({8'd0, offc} << 8) - {8'd0, offc};
            r_rem  <= '0;
            r_cnt  <= 5'(NumW);
        end else if (r_run) begin
            if (trial >= {1'b0, r_span}) begin
                r_rem <= trial - {1'b0, r_span};
                r_num <= {r_num[NumW-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_num <= {r_num[NumW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_run <= 1'b0;
        end
    end

    assign o_done  = !r_run && !i_go;
    assign o_level = r_zero ? rcrs_pkg::LevelFull
                            : rcrs_pkg::LevelFull - r_num[rcrs_pkg::LevelW-1:0];
endmodule

// ----- src/rc_reflectance_sensor_array.sv -----
// Top level of the RC-discharge reflectance sensor array.
// Depends on rcrs_pkg, rcrs_lane, rcrs_div.
//
// Usage: one input word per microsecond tick (mode, pin_levels). Mode start
// clears the run; the following ticks count, ignoring pins during the charge
// phase, then each channel stops at its first low pin or past the timeout.
// Each channel is a lane of its own; all lanes sense in the tick's cycle.
// When all have stopped, min/max update and one result word per channel is
// sent, channel 0 first, last set on the final one.
// A shared bit-serial divider makes each level, channel by channel, so a
// finishing tick holds the input through all divisions plus output stalls;
// other ticks never hold it. Input is not taken while results are pending.
// The output register holds a word until taken; a stalled receiver stalls
// the result sequence and hence the input.
// Reset (synchronous, active low) restores the register defaults, clears the
// run and sets each channel's minimum to 2047 and maximum and threshold to 0.
module rc_reflectance_sensor_array #(
    parameter int unsigned CHANNELS = rcrs_pkg::DefChannels
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_mode,
    input  logic [7:0]                  i_pin_levels,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_channel,
    output logic [10:0]                 o_response_time,
    output logic [7:0]                  o_level,
    output logic                        o_is_black,
    output logic [10:0]                 o_threshold,
    output logic [10:0]                 o_lowest,
    output logic [10:0]                 o_highest,
    output logic                        o_last,
    input  logic                        i_cfg_we,
    input  logic [rcrs_pkg::IdxW-1:0]   i_cfg_index,
    input  logic [rcrs_pkg::RegW-1:0]   i_cfg_data
);
    localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned TW = rcrs_pkg::TimeW;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StDiv  = 2'd1;
    localparam logic [1:0] StOut  = 2'd2;
    localparam logic [1:0] StPrep = 2'd3;

    logic [9:0]    r_charge, r_timeout;
    logic [10:0]   r_cut;
    logic          r_busy;
    logic [TW-1:0] r_count;
    logic [1:0]    r_state, n_state;
    logic [ChW-1:0] r_ch;
    logic          r_upd;

    logic           acc, start, latch, tickb, sense, alldone, go;
    logic [TW-1:0]  cnt_inc;
    logic [ChW-1:0] div_ch;
    rcrs_pkg::t_lane_ctl ctl;
    logic [CHANNELS-1:0] done_v;
    logic [TW-1:0]  resp_v [CHANNELS];
    logic [TW-1:0]  min_v  [CHANNELS];
    logic [TW-1:0]  max_v  [CHANNELS];
    logic [TW-1:0]  thr_v  [CHANNELS];
    logic           div_done;
    logic [7:0]     lvl;

    assign o_ready = (r_state == StIdle) && !r_upd;
    assign acc     = i_valid && o_ready;
    assign start   = acc && i_mode == rcrs_pkg::ModeStart;
    assign latch   = acc && i_mode == rcrs_pkg::ModeLatch;
    assign tickb   = acc && !start && r_busy;
    assign cnt_inc = (r_count < rcrs_pkg::TimeMax) ? r_count + 1'b1 : r_count;
    assign sense   = tickb && cnt_inc > {1'b0, r_charge};
    assign alldone = sense && &done_v;

    assign ctl.sense   = sense;
    assign ctl.count   = cnt_inc;
    assign ctl.timeout = r_timeout;

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_lane
            logic pin;
            if (g < rcrs_pkg::PinBits) begin : g_pin
                assign pin = i_pin_levels[g];
            end else begin : g_nopin
                assign pin = 1'b1;
            end
            rcrs_lane u_lane (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_latch(latch),
                .i_update(r_upd), .i_pin(pin), .i_ctl(ctl), .o_done(done_v[g]),
                .o_resp(resp_v[g]), .o_min(min_v[g]), .o_max(max_v[g]),
                .o_thr(thr_v[g]));
        end
    endgenerate

    // first division is started from the prep state so it sees the updated min/max
    assign go = (r_state == StPrep) ||
                (r_state == StOut && i_ready && 32'(r_ch) != CHANNELS - 1);
    assign div_ch = (r_state == StPrep) ? '0 : ChW'(r_ch + 1'b1);

    rcrs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go),
        .i_resp(resp_v[div_ch]),
        .i_lo(min_v[div_ch]),
        .i_hi(max_v[div_ch]),
        .o_done(div_done), .o_level(lvl));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            StIdle: if (r_upd) n_state = StPrep;
            StPrep: n_state = StDiv;
            StDiv:  if (div_done) n_state = StOut;
            StOut: begin
                if (i_ready) n_state = (32'(r_ch) == CHANNELS - 1) ? StIdle : StDiv;
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge  <= 10'd10;
            r_timeout <= 10'd1000;
            r_cut     <= 11'd128;
            r_busy    <= 1'b0;
            r_count   <= '0;
            r_state   <= StIdle;
            r_ch      <= '0;
            r_upd     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rcrs_pkg::RegCharge:  r_charge  <= i_cfg_data[9:0];
                    rcrs_pkg::RegTimeout: r_timeout <= i_cfg_data[9:0];
                    rcrs_pkg::RegCut:     r_cut     <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state <= n_state;
            r_upd   <= alldone;
            if (start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (tickb) begin
                r_count <= cnt_inc;
                if (alldone) r_busy <= 1'b0;
            end
            if (r_upd) r_ch <= '0;
            else if (r_state == StOut && i_ready) r_ch <= r_ch + 1'b1;
        end
    end

    assign o_valid         = (r_state == StOut);
    assign o_channel       = 3'(r_ch);
    assign o_response_time = resp_v[r_ch];
    assign o_level         = lvl;
    assign o_is_black      = resp_v[r_ch] >= r_cut;
    assign o_threshold     = thr_v[r_ch];
    assign o_lowest        = min_v[r_ch];
    assign o_highest       = max_v[r_ch];
    assign o_last          = 32'(r_ch) == CHANNELS - 1;
endmodule

// ----- verif/tb_rc_reflectance_sensor_array.sv -----
// Testbench for rc_reflectance_sensor_array: random and directed tick words,
// predicted per-channel results checked in order. Depends on rcrs_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic [2:0]  channel;
    logic [10:0] response_time;
    logic [7:0]  level;
    logic        is_black;
    logic [10:0] threshold;
    logic [10:0] lowest;
    logic [10:0] highest;
    logic        last;
} t_result;

class rcrs_scoreboard;
    logic [9:0]  charge_ticks;
    logic [9:0]  timeout_limit;
    logic [10:0] black_cut;
    logic        busy;
    logic [10:0] tick_count;
    logic [7:0]  done_mask;
    logic [10:0] resp[8];
    logic [10:0] min_t[8];
    logic [10:0] max_t[8];
    logic [10:0] thr[8];
    t_result     pending[$];
    int          errors;
    int          runs;

    function void reset_state();
        charge_ticks = 10;
        timeout_limit = 1000;
        black_cut = 128;
        busy = 0;
        tick_count = 0;
        done_mask = 0;
        for (int c = 0; c < 8; c++) begin
            resp[c] = 0;
            min_t[c] = 11'd2047;
            max_t[c] = 0;
            thr[c] = 0;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] val);
        if (idx == rcrs_pkg::RegCharge) charge_ticks = val[9:0];
        else if (idx == rcrs_pkg::RegTimeout) timeout_limit = val[9:0];
        else if (idx == rcrs_pkg::RegCut) black_cut = val;
    endfunction

    function logic [7:0] level_of(logic [10:0] x, logic [10:0] lo, logic [10:0] hi);
        int unsigned span;
        int unsigned off;
        if (hi <= lo) return 8'd255;
        span = hi - lo;
        off = (x > lo) ? x - lo : 0;
        if (off > span) off = span;
        return 8'(255 - (off * 255) / span);
    endfunction

    function void note_word(logic [1:0] mode, logic [7:0] pins);
        t_result r;
        if (mode == rcrs_pkg::ModeStart) begin
            busy = 1;
            tick_count = 0;
            done_mask = 0;
            for (int c = 0; c < 8; c++) resp[c] = 0;
            return;
        end
        if (mode == rcrs_pkg::ModeLatch)
            for (int c = 0; c < 8; c++) thr[c] = 11'((12'(min_t[c]) + 12'(max_t[c])) >> 1);
        if (!busy) return;
        if (tick_count < 11'd2047) tick_count++;
        if (tick_count <= {1'b0, charge_ticks}) return;
        for (int c = 0; c < 8; c++) begin
            if (!done_mask[c] && (!pins[c] || tick_count > {1'b0, timeout_limit})) begin
                done_mask[c] = 1;
                resp[c] = tick_count;
            end
        end
        if (done_mask != 8'hFF) return;
        busy = 0;
        runs++;
        for (int c = 0; c < 8; c++) begin
            if (resp[c] > max_t[c]) max_t[c] = resp[c];
            if (resp[c] < min_t[c]) min_t[c] = resp[c];
            r.channel = 3'(c);
            r.response_time = resp[c];
            r.level = level_of(resp[c], min_t[c], max_t[c]);
            r.is_black = resp[c] >= black_cut;
            r.threshold = thr[c];
            r.lowest = min_t[c];
            r.highest = max_t[c];
            r.last = (c == 7);
            pending.push_back(r);
        end
    endfunction

    function void cmp(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s expected %0d got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(t_result a);
        t_result e;
        if (pending.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
        end
        e = pending.pop_front();
        cmp("channel", e.channel, a.channel);
        cmp("response_time", e.response_time, a.response_time);
        cmp("level", e.level, a.level);
        cmp("is_black", e.is_black, a.is_black);
        cmp("threshold", e.threshold, a.threshold);
        cmp("lowest", e.lowest, a.lowest);
        cmp("highest", e.highest, a.highest);
        cmp("last", e.last, a.last);
    endfunction
endclass

module tb_rc_reflectance_sensor_array;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_mode = 0;
    logic [7:0]  i_pin_levels = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_channel;
    logic [10:0] o_response_time;
    logic [7:0]  o_level;
    logic        o_is_black;
    logic [10:0] o_threshold;
    logic [10:0] o_lowest;
    logic [10:0] o_highest;
    logic        o_last;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [10:0] i_cfg_data = 0;

    rcrs_scoreboard sb;
    int  words_sent;
    bit  hold_off;
    int  burst_left;

    rc_reflectance_sensor_array dut (.*);

    always #4 i_clk = ~i_clk;

    // receiver: own stall pattern, plus one long hold-off
    always @(posedge i_clk) begin
        t_result a;
        if (i_rst_n && o_valid && i_ready) begin
            a = '{o_channel, o_response_time, o_level, o_is_black,
                  o_threshold, o_lowest, o_highest, o_last};
            sb.check_result(a);
        end
        if (hold_off) i_ready <= 0;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        #50ms;
        $display("FAIL rc_reflectance_sensor_array");
        $finish;
    end

    // valid stays up across a burst; dropped only for a gap or by settle()
    task automatic send_word(logic [1:0] mode, logic [7:0] pins);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1;
        i_mode <= mode;
        i_pin_levels <= pins;
        do @(posedge i_clk); while (!o_ready);
        sb.note_word(mode, pins);
        words_sent++;
    endtask

    task automatic settle();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [10:0] val);
        settle();
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 0;
    endtask

    // one measurement: channels drop at random sensing ticks
    task automatic run_measure(int ticks, bit noisy);
        logic [7:0] alive;
        alive = 8'hFF;
        send_word(rcrs_pkg::ModeStart, 8'($urandom));
        for (int t = 1; t <= ticks; t++) begin
            logic [1:0] m;
            if (t > sb.charge_ticks)
                for (int c = 0; c < 8; c++)
                    if ($urandom_range(0, 5) == 0) alive[c] = 0;
            m = ($urandom_range(0, 9) == 0) ? rcrs_pkg::ModeLatch :
                ($urandom_range(0, 19) == 0) ? 2'd3 : rcrs_pkg::ModeTick;
            if (noisy && $urandom_range(0, 9) == 0) m = rcrs_pkg::ModeStart;
            send_word(m, (t <= sb.charge_ticks) ? 8'($urandom) : alive);
            if (!sb.busy) break;
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        burst_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: idle ticks and latch while idle, mode 3
        send_word(rcrs_pkg::ModeTick, 8'h00);
        send_word(rcrs_pkg::ModeLatch, 8'hFF);
        send_word(2'd3, 8'hAA);
        set_reg(rcrs_pkg::RegCharge, 0);
        set_reg(rcrs_pkg::RegTimeout, 1);
        set_reg(rcrs_pkg::RegCut, 0);
        // everything low on first tick, then timeout path
        send_word(rcrs_pkg::ModeStart, 8'hFF);
        send_word(rcrs_pkg::ModeTick, 8'h00);
        send_word(rcrs_pkg::ModeStart, 8'h00);
        send_word(rcrs_pkg::ModeTick, 8'hFF);
        send_word(rcrs_pkg::ModeTick, 8'hFF);
        send_word(rcrs_pkg::ModeLatch, 8'hFF);
        set_reg(rcrs_pkg::RegTimeout, 0);
        send_word(rcrs_pkg::ModeStart, 8'h55);
        send_word(rcrs_pkg::ModeTick, 8'hFF);
        set_reg(rcrs_pkg::RegCut, 11'd1024);
        set_reg(rcrs_pkg::RegCharge, 10'd3);
        set_reg(rcrs_pkg::RegTimeout, 10'd20);
        // restart while busy
        send_word(rcrs_pkg::ModeStart, 8'h00);
        send_word(rcrs_pkg::ModeTick, 8'h00);
        send_word(rcrs_pkg::ModeStart, 8'h00);
        run_measure(40, 0);
        // long receiver hold-off while words keep coming
        hold_off = 1;
        fork
            begin repeat (3000) @(posedge i_clk); hold_off = 0; end
            begin run_measure(40, 0); run_measure(40, 0); end
        join
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin set_reg(rcrs_pkg::RegCharge, 2); set_reg(rcrs_pkg::RegTimeout, 30);
                   set_reg(rcrs_pkg::RegCut, 12); end
                1: begin set_reg(rcrs_pkg::RegCharge, 30); set_reg(rcrs_pkg::RegTimeout, 1023);
                   set_reg(rcrs_pkg::RegCut, 1024); end
                2: begin set_reg(rcrs_pkg::RegCharge, 0); set_reg(rcrs_pkg::RegTimeout, 1);
                   set_reg(rcrs_pkg::RegCut, 2047); end
                default: begin set_reg(rcrs_pkg::RegCharge, 5); set_reg(rcrs_pkg::RegTimeout, 60);
                   set_reg(rcrs_pkg::RegCut, 25); end
            endcase
            if (p == 1) run_measure(60, 0);
            else for (int k = 0; k < 4; k++) run_measure(70, (k % 2) == 1);
            for (int k = 0; k < 8; k++) send_word(2'($urandom), 8'($urandom));
        end
        settle();
        $display("Sent %0d words, %0d measurements completed across several register settings.",
                 words_sent, sb.runs);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS rc_reflectance_sensor_array");
        else
            $display("FAIL rc_reflectance_sensor_array");
        $finish;
    end
endmodule
